// ===== hdl/esc_pkg.sv =====
`default_nettype none
package esc_pkg;

  localparam int MaxColsDef = 32;
  localparam int MaxRowsDef = 64;

  typedef struct packed {
    logic [31:0] row_bits;
    logic        last_row;
  } in_payload_t;

  typedef struct packed {
    logic [31:0] best_cover;
    logic [5:0]  cover_size;
    logic        rows_dropped;
  } out_payload_t;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [2:0] nib [8];
    logic [5:0] s;
    s = 6'd0;
    for (int i = 0; i < 8; i++) begin
      nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(nib[i]);
    end
    return s;
  endfunction

  function automatic logic [16:0] recip(input logic [5:0] w);
    logic [16:0] r;
    case (w)
      6'd1:  r = 17'd65536;
      6'd2:  r = 17'd32768;
      6'd3:  r = 17'd21845;
      6'd4:  r = 17'd16384;
      6'd5:  r = 17'd13107;
      6'd6:  r = 17'd10922;
      6'd7:  r = 17'd9362;
      6'd8:  r = 17'd8192;
      6'd9:  r = 17'd7281;
      6'd10: r = 17'd6553;
      6'd11: r = 17'd5957;
      6'd12: r = 17'd5461;
      6'd13: r = 17'd5041;
      6'd14: r = 17'd4681;
      6'd15: r = 17'd4369;
      6'd16: r = 17'd4096;
      6'd17: r = 17'd3855;
      6'd18: r = 17'd3640;
      6'd19: r = 17'd3449;
      6'd20: r = 17'd3276;
      6'd21: r = 17'd3120;
      6'd22: r = 17'd2978;
      6'd23: r = 17'd2849;
      6'd24: r = 17'd2730;
      6'd25: r = 17'd2621;
      6'd26: r = 17'd2520;
      6'd27: r = 17'd2427;
      6'd28: r = 17'd2340;
      6'd29: r = 17'd2259;
      6'd30: r = 17'd2184;
      6'd31: r = 17'd2114;
      6'd32: r = 17'd2048;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/esc_ram.sv =====
`default_nettype none
module esc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/exact_minimum_set_cover.sv =====
`default_nettype none
// Exact minimum set cover solver.
// Input channel: a row transfers at a rising edge with start high and busy
// low, one row per cycle while loading. Bit c of row_bits marks column c.
// A row with last_row set ends the matrix and starts the solve; busy stays
// high until the result has been shown. Rows past MAX_ROWS are dropped and
// flagged in rows_dropped.
// Result channel: out_valid is high for one cycle with best_cover,
// cover_size and rows_dropped; the receiver cannot stall it.
// Configuration: APB register 0 (byte address 0) holds active_columns,
// reset 32; pready is always high.
// Search: a node's reduction round runs the essential-column sweep, the
// row-removal sweep, a dominance sweep per live row and per active column,
// reading the row store one row per cycle. A node then sweeps for its cover
// check; a branch scores columns, picks the split and pushes a stack entry;
// backtrack pops levels. The solve starts the cycle after the last row and
// the result the cycle after the search ends; time depends on the search tree.
// Reset: control and best mask clear at once; no memory clearing pass.
module exact_minimum_set_cover #(
  parameter int MAX_COLS = esc_pkg::MaxColsDef,
  parameter int MAX_ROWS = esc_pkg::MaxRowsDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire esc_pkg::in_payload_t in_data,
  output logic                      out_valid,
  output esc_pkg::out_payload_t     out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);
  import esc_pkg::*;

  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int LVW   = $clog2(MAX_COLS + 1);
  localparam int SUMW  = 17 + $clog2(MAX_ROWS);
  localparam int STW   = MAX_ROWS + 70;
  localparam int CLAMP = (MAX_COLS < 32) ? MAX_COLS : 32;
  localparam logic RegActiveCols = 1'b0;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_ESS1, S_ESS2, S_RDA, S_RDAW, S_RDB, S_CDA, S_CDB,
    S_COVER, S_DECIDE, S_SPLIT, S_ARGMAX, S_PUSH, S_TAKE, S_BACK, S_BACKW, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic ovf_r, ovf_nxt;
  logic [5:0] active_r, active_nxt;
  logic [RCW-1:0] cnt_r, cnt_nxt;
  logic rv_r, rv_nxt;
  logic [RIW-1:0] ri_r, ri_nxt;
  logic [LVW-1:0] level_r, level_nxt;
  logic [31:0] best_r, best_nxt;
  logic [5:0] best_cnt_r, best_cnt_nxt;

  logic [MAX_ROWS-1:0] rows_r, rows_nxt;
  logic [31:0] cols_r, cols_nxt, chosen_r, chosen_nxt;
  logic [31:0] kmask_r, kmask_nxt, umask_r, umask_nxt, bad_r, bad_nxt, rowa_r, rowa_nxt;
  logic ch_r, ch_nxt, uncov_r, uncov_nxt, found_r, found_nxt;
  logic [RCW-1:0] a_r, a_nxt;
  logic [5:0] ca_r, ca_nxt;
  logic [4:0] split_r, split_nxt;
  logic [SUMW-1:0] bs_r, bs_nxt;
  logic [SUMW-1:0] sum_r [32];
  logic [SUMW-1:0] sum_nxt [32];

  logic accept, sweep_st, issue, sweep_done, live;
  logic [5:0] ncols, cc, w;
  logic [16:0] rc;
  logic [32:0] all_t;
  logic [MAX_ROWS:0] rows_t;
  logic [31:0] rdata, m, rem;
  logic row_we, stk_we;
  logic [RIW-1:0] row_raddr;
  logic [LVW-1:0] stk_raddr;
  logic [STW-1:0] stk_wdata, sd;

  assign accept = start && (state_r == S_LOAD);
  assign busy   = (state_r != S_LOAD);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegActiveCols) ? {26'd0, active_r} : 32'd0;

  always_comb begin
    if (active_r == 6'd0) ncols = 6'd1;
    else if (active_r > 6'(CLAMP)) ncols = 6'(CLAMP);
    else ncols = active_r;
  end
  assign all_t  = (33'd1 << ncols) - 33'd1;
  assign rows_t = ({{MAX_ROWS{1'b0}}, 1'b1} << row_count_r) - {{MAX_ROWS{1'b0}}, 1'b1};

  assign sweep_st = (state_r == S_ESS1) || (state_r == S_ESS2) || (state_r == S_RDB) ||
                    (state_r == S_CDB) || (state_r == S_COVER) || (state_r == S_SPLIT) ||
                    (state_r == S_TAKE);
  assign issue      = sweep_st && (cnt_r < row_count_r);
  assign sweep_done = sweep_st && !issue && !rv_r;
  assign live       = rows_r[ri_r];

  assign row_we    = accept && (row_count_r < RCW'(MAX_ROWS));
  assign row_raddr = (state_r == S_RDA) ? a_r[RIW-1:0] : cnt_r[RIW-1:0];

  esc_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_count_r[RIW-1:0]), .wdata(in_data.row_bits),
    .raddr(row_raddr), .rdata(rdata)
  );

  assign stk_we    = (state_r == S_PUSH) || ((state_r == S_BACKW) && !sd[5]);
  assign stk_wdata = (state_r == S_PUSH) ? {rows_r, cols_r, chosen_r, 1'b0, split_r}
                                         : {sd[STW-1:6], 1'b1, sd[4:0]};
  assign stk_raddr = level_r - LVW'(1);

  esc_ram #(.WIDTH(STW), .DEPTH(MAX_COLS + 1)) u_stack (
    .clk(clk), .we(stk_we), .waddr(level_r), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(sd)
  );

  assign m  = rdata & cols_r;
  assign w  = popcount32(m);
  assign rc = recip(w);
  assign cc = popcount32(chosen_r);
  assign rem = cols_r & ~bad_r & ~(32'd1 << ca_r[4:0]);

  always_comb begin
    state_nxt = state_r; row_count_nxt = row_count_r; ovf_nxt = ovf_r;
    active_nxt = active_r; cnt_nxt = cnt_r; rv_nxt = issue; ri_nxt = cnt_r[RIW-1:0];
    level_nxt = level_r; best_nxt = best_r; best_cnt_nxt = best_cnt_r;
    rows_nxt = rows_r; cols_nxt = cols_r; chosen_nxt = chosen_r; kmask_nxt = kmask_r;
    umask_nxt = umask_r; bad_nxt = bad_r; rowa_nxt = rowa_r; ch_nxt = ch_r;
    uncov_nxt = uncov_r; found_nxt = found_r; a_nxt = a_r; ca_nxt = ca_r;
    split_nxt = split_r; bs_nxt = bs_r;
    for (int c = 0; c < 32; c++) sum_nxt[c] = sum_r[c];

    if (psel && penable && pwrite && (paddr[2] == RegActiveCols)) active_nxt = pwdata[5:0];
    if (issue) cnt_nxt = cnt_r + RCW'(1);
    if (sweep_done) cnt_nxt = '0;

    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (row_we) row_count_nxt = row_count_r + RCW'(1);
          else ovf_nxt = 1'b1;
          if (in_data.last_row) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        best_nxt = all_t[31:0]; best_cnt_nxt = ncols;
        rows_nxt = rows_t[MAX_ROWS-1:0]; cols_nxt = all_t[31:0]; chosen_nxt = '0;
        level_nxt = '0; ch_nxt = 1'b0; kmask_nxt = '0; state_nxt = S_ESS1;
      end
      S_ESS1: begin
        if (rv_r && live && ((rdata & kmask_r) == 32'd0) && (m != 32'd0) &&
            ((m & (m - 32'd1)) == 32'd0)) begin
          chosen_nxt = chosen_r | m; cols_nxt = cols_r & ~m;
          kmask_nxt = kmask_r | m; ch_nxt = 1'b1;
        end
        if (sweep_done) begin
          umask_nxt = '0; state_nxt = S_ESS2;
        end
      end
      S_ESS2: begin
        if (rv_r && live) begin
          if ((rdata & kmask_r) != 32'd0) rows_nxt[ri_r] = 1'b0;
          else umask_nxt = umask_r | rdata;
        end
        if (sweep_done) begin
          cols_nxt = cols_r & umask_r;
          if ((cols_r & ~umask_r) != 32'd0) ch_nxt = 1'b1;
          a_nxt = '0; state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        if (a_r == row_count_r) begin
          ca_nxt = '0; state_nxt = S_CDA;
        end else if (!rows_r[a_r[RIW-1:0]]) begin
          a_nxt = a_r + RCW'(1);
        end else begin
          state_nxt = S_RDAW;
        end
      end
      S_RDAW: begin
        rowa_nxt = rdata; state_nxt = S_RDB;
      end
      S_RDB: begin
        if (rv_r && live && (ri_r != a_r[RIW-1:0]) &&
            ((rowa_r & cols_r & ~rdata) == 32'd0)) begin
          rows_nxt[ri_r] = 1'b0; ch_nxt = 1'b1;
        end
        if (sweep_done) begin
          a_nxt = a_r + RCW'(1); state_nxt = S_RDA;
        end
      end
      S_CDA: begin
        if (ca_r == ncols) begin
          if (ch_r) begin
            ch_nxt = 1'b0; kmask_nxt = '0; state_nxt = S_ESS1;
          end else begin
            uncov_nxt = 1'b0; state_nxt = S_COVER;
          end
        end else if (!cols_r[ca_r[4:0]]) begin
          ca_nxt = ca_r + 6'd1;
        end else begin
          bad_nxt = '0; state_nxt = S_CDB;
        end
      end
      S_CDB: begin
        if (rv_r && live) bad_nxt = bad_r | (rdata & ~{32{rdata[ca_r[4:0]]}});
        if (sweep_done) begin
          cols_nxt = cols_r & ~rem;
          if (rem != 32'd0) ch_nxt = 1'b1;
          ca_nxt = ca_r + 6'd1; state_nxt = S_CDA;
        end
      end
      S_COVER: begin
        if (rv_r && live && (m == 32'd0)) uncov_nxt = 1'b1;
        if (sweep_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (uncov_r || (cc >= best_cnt_r)) begin
          state_nxt = S_BACK;
        end else if (rows_r == '0) begin
          best_nxt = chosen_r; best_cnt_nxt = cc; state_nxt = S_BACK;
        end else if ((cols_r == 32'd0) || (level_r >= LVW'(MAX_COLS))) begin
          state_nxt = S_BACK;
        end else begin
          for (int c = 0; c < 32; c++) sum_nxt[c] = '0;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (rv_r && live) begin
          for (int c = 0; c < 32; c++) begin
            if (m[c]) sum_nxt[c] = sum_r[c] + SUMW'(rc);
          end
        end
        if (sweep_done) begin
          ca_nxt = '0; found_nxt = 1'b0; state_nxt = S_ARGMAX;
        end
      end
      S_ARGMAX: begin
        if (ca_r == 6'd32) begin
          state_nxt = S_PUSH;
        end else begin
          if (cols_r[ca_r[4:0]] && (!found_r || (sum_r[ca_r[4:0]] > bs_r))) begin
            bs_nxt = sum_r[ca_r[4:0]]; split_nxt = ca_r[4:0]; found_nxt = 1'b1;
          end
          ca_nxt = ca_r + 6'd1;
        end
      end
      S_PUSH: begin
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        if (rv_r && rdata[split_r]) rows_nxt[ri_r] = 1'b0;
        if (sweep_done) begin
          cols_nxt = cols_r & ~(32'd1 << split_r);
          chosen_nxt = chosen_r | (32'd1 << split_r);
          level_nxt = level_r + LVW'(1);
          ch_nxt = 1'b0; kmask_nxt = '0; state_nxt = S_ESS1;
        end
      end
      S_BACK: begin
        if (level_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          level_nxt = level_r - LVW'(1); state_nxt = S_BACKW;
        end
      end
      S_BACKW: begin
        if (!sd[5]) begin
          rows_nxt = sd[STW-1:70];
          cols_nxt = sd[69:38] & ~(32'd1 << sd[4:0]);
          chosen_nxt = sd[37:6];
          level_nxt = level_r + LVW'(1);
          ch_nxt = 1'b0; kmask_nxt = '0; state_nxt = S_ESS1;
        end else begin
          state_nxt = S_BACK;
        end
      end
      S_OUT: begin
        row_count_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; row_count_r <= '0; ovf_r <= 1'b0; active_r <= 6'd32;
      cnt_r <= '0; rv_r <= 1'b0; level_r <= '0; best_r <= '0; best_cnt_r <= '0;
    end else begin
      state_r <= state_nxt; row_count_r <= row_count_nxt; ovf_r <= ovf_nxt;
      active_r <= active_nxt; cnt_r <= cnt_nxt; rv_r <= rv_nxt; level_r <= level_nxt;
      best_r <= best_nxt; best_cnt_r <= best_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ri_r <= ri_nxt; rows_r <= rows_nxt; cols_r <= cols_nxt; chosen_r <= chosen_nxt;
    kmask_r <= kmask_nxt; umask_r <= umask_nxt; bad_r <= bad_nxt; rowa_r <= rowa_nxt;
    ch_r <= ch_nxt; uncov_r <= uncov_nxt; found_r <= found_nxt; a_r <= a_nxt;
    ca_r <= ca_nxt; split_r <= split_nxt; bs_r <= bs_nxt;
    for (int c = 0; c < 32; c++) sum_r[c] <= sum_nxt[c];
  end

  assign out_valid = (state_r == S_OUT);
  assign out_data.best_cover   = best_r;
  assign out_data.cover_size   = best_cnt_r;
  assign out_data.rows_dropped = ovf_r;

  a_out_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cover_size == 6'($countones(out_data.best_cover))))
    else $error("cover_size does not match best_cover");

  a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_row) |=> busy)
    else $error("solve did not start after last row");

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block not idle after result");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= RCW'(MAX_ROWS))
    else $error("row count beyond store depth");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
  import esc_pkg::*;

  localparam int WatchdogLimit = 2000000;
  localparam int SettleCycles = 60;
  localparam logic [2:0] AddrActiveColumns = 3'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_payload_t in_data = '0;
  logic out_valid;
  out_payload_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  in_payload_t row_queue[$];
  out_payload_t cover_queue[$];
  int error_count = 0;
  int idle_pct = 22;
  int stall_cycles = 0;
  bit activity = 1'b0;

  logic [31:0] row_mem[64];
  int stored_rows = 0;
  bit dropped = 1'b0;
  logic [5:0] col_setting = 6'd32;

  logic [63:0] col_map[32];
  int n_rows;
  int n_cols;
  logic [31:0] best_cols;
  logic [63:0] lv_rows[33];
  logic [31:0] lv_cols[33];
  logic [31:0] lv_pick[33];
  bit lv_phase[33];

  exact_minimum_set_cover DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int bit_total(logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) n += v[i];
    return n;
  endfunction

  function automatic bit reduce_node(int l);
    logic [63:0] rows;
    logic [31:0] cols;
    logic [31:0] pick;
    logic [31:0] m;
    bit chg;
    int c;
    rows = lv_rows[l];
    cols = lv_cols[l];
    pick = lv_pick[l];
    chg = 1'b1;
    while (chg) begin
      chg = 1'b0;
      for (int r = 0; r < n_rows; r++) begin
        if (rows[r]) begin
          m = row_mem[r] & cols;
          if (m != 0 && (m & (m - 1)) == 0) begin
            c = 0;
            while (c < 31 && !m[c]) c++;
            pick |= m;
            cols &= ~m;
            rows &= ~col_map[c];
            chg = 1'b1;
          end
        end
      end
      for (int k = 0; k < n_cols; k++) begin
        if (cols[k] && (col_map[k] & rows) == 0) begin
          cols[k] = 1'b0;
          chg = 1'b1;
        end
      end
      for (int a = 0; a < n_rows; a++) begin
        if (!rows[a]) continue;
        for (int b = 0; b < n_rows; b++) begin
          if (b == a || !rows[b]) continue;
          if ((row_mem[a] & cols & ~row_mem[b]) == 0) begin
            rows[b] = 1'b0;
            chg = 1'b1;
          end
        end
      end
      for (int a = 0; a < n_cols; a++) begin
        if (!cols[a]) continue;
        for (int b = 0; b < n_cols; b++) begin
          if (b == a || !cols[b]) continue;
          if ((col_map[b] & rows & ~col_map[a]) == 0) begin
            cols[b] = 1'b0;
            chg = 1'b1;
          end
        end
      end
    end
    lv_rows[l] = rows;
    lv_cols[l] = cols;
    lv_pick[l] = pick;
    for (int r = 0; r < n_rows; r++)
      if (rows[r] && (row_mem[r] & cols) == 0) return 1'b0;
    if (bit_total(pick) >= bit_total(best_cols)) return 1'b0;
    if (rows == 0) begin
      best_cols = pick;
      return 1'b0;
    end
    if (cols == 0) return 1'b0;
    lv_phase[l] = 1'b0;
    return 1'b1;
  endfunction

  function automatic void branch_child(int l, bit take);
    int weight[64];
    longint top_sum;
    longint sum;
    int s;
    logic [31:0] one;
    top_sum = -1;
    s = 0;
    for (int r = 0; r < n_rows; r++)
      weight[r] = lv_rows[l][r] ? bit_total(64'(row_mem[r] & lv_cols[l])) : 0;
    for (int c = 0; c < n_cols; c++) begin
      if (!lv_cols[l][c]) continue;
      sum = 0;
      for (int r = 0; r < n_rows; r++)
        if (lv_rows[l][r] && row_mem[r][c] && weight[r] != 0) sum += 65536 / weight[r];
      if (sum > top_sum) begin
        top_sum = sum;
        s = c;
      end
    end
    one = 32'd1 << s;
    lv_cols[l + 1] = lv_cols[l] & ~one;
    lv_rows[l + 1] = take ? (lv_rows[l] & ~col_map[s]) : lv_rows[l];
    lv_pick[l + 1] = take ? (lv_pick[l] | one) : lv_pick[l];
  endfunction

  function automatic void solve_cover();
    logic [31:0] all_cols;
    int lvl;
    bit descend;
    all_cols = (n_cols >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n_cols) - 1);
    for (int c = 0; c < 32; c++) begin
      col_map[c] = '0;
      for (int r = 0; r < n_rows; r++) if (row_mem[r][c]) col_map[c][r] = 1'b1;
    end
    best_cols = all_cols;
    lv_rows[0] = (n_rows >= 64) ? '1 : ((64'd1 << n_rows) - 1);
    lv_cols[0] = all_cols;
    lv_pick[0] = '0;
    lvl = 0;
    descend = reduce_node(0);
    forever begin
      if (descend && lvl < 32) begin
        branch_child(lvl, 1'b1);
        lvl++;
        descend = reduce_node(lvl);
        continue;
      end
      if (lvl == 0) break;
      lvl--;
      if (!lv_phase[lvl]) begin
        lv_phase[lvl] = 1'b1;
        branch_child(lvl, 1'b0);
        lvl++;
        descend = reduce_node(lvl);
      end else begin
        descend = 1'b0;
      end
    end
  endfunction

  function automatic void take_row(in_payload_t item);
    out_payload_t res;
    if (stored_rows < 64) begin
      row_mem[stored_rows] = item.row_bits;
      stored_rows++;
    end else begin
      dropped = 1'b1;
    end
    if (!item.last_row) return;
    n_cols = (col_setting == 0) ? 1 : ((col_setting > 32) ? 32 : int'(col_setting));
    n_rows = stored_rows;
    solve_cover();
    res.best_cover = best_cols;
    res.cover_size = 6'(bit_total(64'(best_cols)));
    res.rows_dropped = dropped;
    cover_queue.insert(cover_queue.size(), res);
    stored_rows = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) take_row(in_data);
      if (!start || !busy) begin
        if (row_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= row_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cover_queue.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        if (out_data.best_cover !== cover_queue[0].best_cover) begin
          $error("best_cover expected %h actual %h", cover_queue[0].best_cover,
                 out_data.best_cover);
          error_count++;
        end
        if (out_data.cover_size !== cover_queue[0].cover_size) begin
          $error("cover_size expected %0d actual %0d", cover_queue[0].cover_size,
                 out_data.cover_size);
          error_count++;
        end
        if (out_data.rows_dropped !== cover_queue[0].rows_dropped) begin
          $error("rows_dropped expected %0d actual %0d", cover_queue[0].rows_dropped,
                 out_data.rows_dropped);
          error_count++;
        end
        void'(cover_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || activity) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_columns(logic [5:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrActiveColumns;
    pwdata <= 32'(value);
    activity <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    activity <= 1'b0;
    col_setting = value;
  endtask

  task automatic add_row(logic [31:0] bits, logic last);
    in_payload_t item;
    item.row_bits = bits;
    item.last_row = last;
    row_queue.insert(row_queue.size(), item);
  endtask

  function automatic logic [31:0] random_row(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom() & $urandom();
      2: return $urandom() & $urandom() & $urandom();
      default: return 32'd1 << $urandom_range(31);
    endcase
  endfunction

  task automatic wait_idle();
    wait (row_queue.size() == 0 && cover_queue.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    wait (!busy && !start);
  endtask

  initial begin
    logic [5:0] settings[8];
    int budget;
    int rows;
    int mode;
    settings = '{6'd32, 6'd1, 6'd0, 6'd4, 6'd63, 6'd8, 6'd20, 6'd32};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 8; p++) begin
      write_columns(settings[p]);
      idle_pct = (p == 3) ? 0 : 22;
      if (p == 0) begin
        add_row(32'hFFFF_FFFF, 1'b1);
        add_row(32'h0000_0000, 1'b1);
        add_row(32'h8000_0001, 1'b0);
        add_row(32'h0000_0003, 1'b0);
        add_row(32'h8000_0000, 1'b1);
        add_row(32'h0000_0007, 1'b0);
        add_row(32'h0000_000E, 1'b0);
        add_row(32'h0000_0019, 1'b0);
        add_row(32'h0000_0000, 1'b1);
        for (int r = 0; r < 66; r++) add_row(32'd1 << (r % 32), r == 65);
        for (int r = 0; r < 64; r++) add_row(32'd1 << (r % 32), r == 63);
      end
      budget = 175;
      while (budget > 0) begin
        rows = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        mode = $urandom_range(3);
        for (int r = 0; r < rows; r++) add_row(random_row(mode), r == rows - 1);
        budget -= rows;
      end
      wait_idle();
    end
    repeat (SettleCycles) @(posedge clk);
    if (cover_queue.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
